[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hcfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcfr_pkg
// Shared types, constants and helpers of the hex checksum frame receiver.
// ----------------------------------------------------------------------------
package hcfr_pkg;

    localparam int DEFAULT_STORE_DEPTH = 64;
    localparam logic [7:0] STOP_BYTE_RESET = 8'd10;
    localparam logic [7:0] SUM_RESET = 8'd1;

    localparam logic [7:0] ASCII_0 = 8'h30;
    localparam logic [7:0] ASCII_9 = 8'h39;
    localparam logic [7:0] ASCII_A = 8'h41;
    localparam logic [7:0] ASCII_F = 8'h46;
    localparam logic [7:0] HEX_A_VALUE = 8'd10;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic       frame_ready;
        logic [6:0] frame_length;
        logic       checksum_ok;
        logic       overflow_error;
    } status_t;

    // Non-hex characters decode as 0.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= ASCII_0 && c <= ASCII_9)
        begin
            v = c - ASCII_0;
        end
        else if (c >= ASCII_A && c <= ASCII_F)
        begin
            v = c - ASCII_A + HEX_A_VALUE;
        end
        return v[3:0];
    endfunction

endpackage

[design/hcfr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/hcfr_rx_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcfr_rx_core
// Receiver state: byte count, running sum, checksum digits, frame and error
// flags. Applies one transaction per step and gives the updated status.
// ----------------------------------------------------------------------------
module hcfr_rx_core #(
    parameter int STORE_DEPTH = hcfr_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_data,
    input  logic                           step,
    input  logic [1:0]                     cmd,
    input  logic [7:0]                     rx_byte,
    output hcfr_pkg::status_t              status_next,
    output logic                           wr_en,
    output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
    output logic [7:0]                     wr_data
);
    import hcfr_pkg::*;

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    logic [7:0]    stop_byte_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    last_reg, last_next;
    logic [7:0]    second_reg, second_next;
    logic          held_reg, held_next;
    logic          ok_reg, ok_next;
    logic          err_reg, err_next;

    logic [7:0]    expect_sum;
    logic [7:0]    got_sum;
    logic          is_stop;
    logic [CW+6:0] length_wide;

    assign expect_sum = sum_reg - second_reg - last_reg;
    assign got_sum = {hex_digit(second_reg), hex_digit(last_reg)};
    assign is_stop = (rx_byte == stop_byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_byte_reg <= STOP_BYTE_RESET;
            count_reg     <= '0;
            sum_reg       <= SUM_RESET;
            last_reg      <= 8'd0;
            second_reg    <= 8'd0;
            held_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                stop_byte_reg <= cfg_data;
            end
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            last_reg   <= last_next;
            second_reg <= second_next;
            held_reg   <= held_next;
            ok_reg     <= ok_next;
            err_reg    <= err_next;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        second_next = second_reg;
        held_next   = held_reg;
        ok_next     = ok_reg;
        err_next    = err_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = rx_byte;
        if (step)
        begin
            case (cmd)
                CMD_BYTE:
                begin
                    if (!held_reg && !err_reg)
                    begin
                        if (is_stop)
                        begin
                            held_next = 1'b1;
                            if (count_reg >= TWO_C)
                            begin
                                count_next = count_reg - TWO_C;
                                ok_next    = (expect_sum == got_sum);
                            end
                            else
                            begin
                                count_next = '0;
                                ok_next    = 1'b0;
                            end
                        end
                        else if (count_reg < DEPTH_C)
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CW'(1);
                            sum_next    = sum_reg + rx_byte;
                            second_next = last_reg;
                            last_next   = rx_byte;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (err_reg && is_stop)
                    begin
                        err_next    = 1'b0;
                        count_next  = '0;
                        sum_next    = SUM_RESET;
                        last_next   = 8'd0;
                        second_next = 8'd0;
                        ok_next     = 1'b0;
                    end
                end
                CMD_RELEASE:
                begin
                    held_next   = 1'b0;
                    count_next  = '0;
                    sum_next    = SUM_RESET;
                    last_next   = 8'd0;
                    second_next = 8'd0;
                    ok_next     = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign length_wide = {7'd0, count_next};

    always_comb
    begin
        status_next.frame_ready    = held_next;
        status_next.frame_length   = held_next ? length_wide[6:0] : 7'd0;
        status_next.checksum_ok    = held_next && ok_next;
        status_next.overflow_error = err_next;
    end

endmodule

[design/hex_checksum_frame_receiver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_checksum_frame_receiver_top
// Stop-byte framed receiver with additive hex checksum and payload readback.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       in_valid / in_stall    cmd, rx_byte, read_index
// out      out_valid / out_stall  frame_ready, frame_length, checksum_ok,
//                                 overflow_error, read_data
// cfg      cfg_valid / cfg_ready  cfg_data (stop byte)
//
// One transaction per cycle unless out_stall holds the result; each passes
// the input register, then the result and payload RAM read registers.
// rst_n is asynchronous; the payload store holds no reset.
// out_stall holds the result register; in_stall rises only when both the
// input register and the result register are full and out_stall is high.
// ----------------------------------------------------------------------------
module hex_checksum_frame_receiver_top #(
    parameter int STORE_DEPTH = hcfr_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] rx_byte,
    input  logic [5:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_ready,
    output logic [6:0] frame_length,
    output logic       checksum_ok,
    output logic       overflow_error,
    output logic [7:0] read_data
);
    import hcfr_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = $clog2(STORE_DEPTH);

    logic          s1_valid_reg;
    logic [1:0]    s1_cmd_reg;
    logic [7:0]    s1_byte_reg;
    logic [5:0]    s1_index_reg;
    logic          out_valid_reg;
    status_t       status_reg;
    logic          rd_sel_reg;

    logic          s1_move;
    logic          in_fire;
    status_t       status_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_hit;
    logic          rd_en;
    logic [AW+5:0] rd_addr_wide;
    logic [7:0]    ram_rdata;

    assign cfg_ready = 1'b1;
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_fire   = in_valid && !in_stall;

    assign rd_hit       = ({26'd0, s1_index_reg} < STORE_DEPTH);
    assign rd_en        = s1_move && (s1_cmd_reg == CMD_READ) && rd_hit;
    assign rd_addr_wide = {{AW{1'b0}}, s1_index_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg   <= cmd;
            s1_byte_reg  <= rx_byte;
            s1_index_reg <= read_index;
        end
        if (s1_move)
        begin
            status_reg <= status_next;
            rd_sel_reg <= rd_en;
        end
    end

    hcfr_rx_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .step        (s1_move),
        .cmd         (s1_cmd_reg),
        .rx_byte     (s1_byte_reg),
        .status_next (status_next),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    hcfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr_wide[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign frame_ready    = status_reg.frame_ready;
    assign frame_length   = status_reg.frame_length;
    assign checksum_ok    = status_reg.checksum_ok;
    assign overflow_error = status_reg.overflow_error;
    assign read_data      = rd_sel_reg ? ram_rdata : 8'd0;

    `ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_reg && out_valid_reg && out_stall, "in_stall without full pipeline")
    `ASSERT_NEXT(a_accept_loads_stage, in_valid && !in_stall, s1_valid_reg, "accepted transaction lost")
    `ASSERT_NOW(a_held_excludes_error, out_valid && frame_ready, !overflow_error, "frame held during overflow")
    `ASSERT_NOW(a_idle_status_clear, out_valid && !frame_ready, frame_length == 7'd0 && !checksum_ok, "status without held frame")

endmodule
